// ===== hw/rtl/spcl_pkg.sv =====
// Shared types and constants of the speed PI regulator with current limit.
`timescale 1ns / 1ps
package spcl_pkg;

  localparam int MAG_W  = 33;  // magnitude operand of the shared multiplier
  localparam int MB_W   = 32;  // second operand of the shared multiplier
  localparam int PROD_W = MAG_W + MB_W;
  localparam int DVD_W  = 57;  // dividend of the preset divider
  localparam int DSR_W  = 24;  // divisor of the preset divider (integral gain)
  localparam int INT_W  = 60;  // working width of an integral during one item

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [INT_W-1:0] ISUM_MAX = INT_W'(655360000);
  localparam logic signed [INT_W-1:0] ISUM_MIN = -INT_W'(655360000);

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_SPEED = 3'd1;
  localparam logic [2:0] CFG_ILIM  = 3'd2;
  localparam logic [2:0] CFG_CKP   = 3'd3;
  localparam logic [2:0] CFG_CKI   = 3'd4;
  localparam logic [2:0] CFG_SKP   = 3'd5;
  localparam logic [2:0] CFG_SKI   = 3'd6;
  localparam logic [2:0] CFG_EMF   = 3'd7;

  localparam logic [30:0] RST_SPEED = 31'd2435938;
  localparam logic [30:0] RST_ILIM  = 31'd5505024;
  localparam logic [23:0] RST_KP    = 24'd131072;
  localparam logic [23:0] RST_KI    = 24'd32768;
  localparam logic [23:0] RST_EMF   = 24'd726;

  typedef enum logic [1:0] {
    LOOP_NONE = 2'd0,
    LOOP_CUR  = 2'd1,
    LOOP_SPD  = 2'd2
  } loop_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_PMUL, ST_PRE, ST_DIV, ST_INC,
    ST_ADD, ST_KI, ST_SUM, ST_FLR, ST_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== hw/rtl/spcl_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module spcl_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [spcl_pkg::MAG_W-1:0] a_i,
  input  logic [spcl_pkg::MB_W-1:0]  b_i,
  output logic [spcl_pkg::PROD_W-1:0] p_o
);
  import spcl_pkg::*;

  logic [PROD_W-1:0] p_q;

  // Hold the product until the next issue.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/spcl_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bumpless preset.
`timescale 1ns / 1ps
module spcl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [spcl_pkg::DVD_W-1:0] dividend_i,
  input  logic [spcl_pkg::DSR_W-1:0] divisor_i,
  output spcl_pkg::div_ctl_t         ctl_o,
  output logic [spcl_pkg::DVD_W-1:0] quot_o
);
  import spcl_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DSR_W:0]   shl;
  logic [DSR_W:0]   trial;

  always_comb begin
    shl    = {rem_q, quo_q[DVD_W-1]};
    trial  = shl - {1'b0, dsr_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shl >= {1'b0, dsr_q}) begin
        rem_d = trial[DSR_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shl[DSR_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/speed_pi_with_current_limit_unit.sv =====
// Top level of the speed PI regulator with current limit and bumpless switching.
// Usage:
//   s_axis carries one measurement word (current, speed, step time); m_axis
//   returns one result word per measurement (PI output, drive fraction) with the
//   active loop in tuser. All numbers are fixed point Q16.16 or Q1.16.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write the eight setup registers; write them
//   only while no measurement is in flight.
// Timing:
//   One word at a time; s_axis_tready is high only while the sequencer idles.
//   A word without a loop switch reaches m_axis through SEL, INC, ADD, KI, SUM, FLR
//   and FIN, in mode 0 through SEL, FLR and FIN. A loop switch with nonzero integral
//   gain adds the preset: the PMUL and PRE states plus the 57-bit restoring divider.
//   All products go through one shared multiplier, one per cycle.
//   The next word is taken the cycle after the result word leaves.
// Reset:
//   rst_ni clears the loop selection, both integrals and the last output, and
//   loads the default setup registers.
// Stall:
//   While m_axis_tready is low the result word holds and no new word enters.
`timescale 1ns / 1ps
module speed_pi_with_current_limit_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] measured_current, [63:32] measured_speed, [95:64] step_time
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] regulator_output, [33:17] drive_fraction, [39:34] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] active_loop
  output logic [1:0]  m_axis_tuser
);
  import spcl_pkg::*;

  // Setup registers.
  logic        mode_q;
  logic [30:0] sp_q, il_q;
  logic [23:0] ckp_q, cki_q, skp_q, ski_q, emf_q;

  // Regulator state.
  state_e             state_q, state_d;
  loop_e              sel_q;
  logic signed [31:0] cint_q, sint_q;
  logic [16:0]        last_q;

  // Item and working registers.
  logic signed [31:0]      cur_q, spd_q;
  logic [31:0]             h_q;
  logic signed [33:0]      e_q;
  logic signed [INT_W-1:0] int_q;
  logic signed [42:0]      acc_q;
  logic [16:0]             y_q;
  logic                    nneg_q;
  logic [16:0]             oy_q, od_q;
  loop_e                   ol_q;
  logic                    mval_q;

  // Shared units.
  logic              mul_en;
  logic [MAG_W-1:0]  mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  div_ctl_t          div_ctl;
  logic [DVD_W-1:0]  div_q;

  // Selection logic.
  logic signed [33:0] es, ei, spd34, es_abs;
  logic signed [40:0] es100, ei100;
  logic               enter_cur, enter_spd;
  loop_e              new_sel;

  // Arithmetic helpers.
  logic [MAG_W-1:0]        e_mag, int_mag, spd_mag;
  logic [23:0]             kp_a, ki_a, ki_new;
  logic signed [42:0]      p16, p_s, num, y_sum, fl_s;
  logic [40:0]             num_mag;
  logic signed [INT_W-1:0] inc_s, int_sum, int_sat, int_abs;
  logic signed [33:0]      spd_abs;
  logic [16:0]             y_clamp, drive;

  always_comb begin
    spd34  = {{2{spd_q[31]}}, spd_q};
    es     = $signed({3'b000, sp_q}) - spd34;
    ei     = $signed({3'b000, il_q}) - $signed({{2{cur_q[31]}}, cur_q});
    es_abs = es[33] ? -es : es;
    es100  = $signed({7'd0, es_abs}) * 41'sd100;
    ei100  = $signed({{7{ei[33]}}, ei}) * 41'sd100;
    enter_cur = (es > 0) && (ei <= 0) && (sel_q != LOOP_CUR);
    enter_spd = !enter_cur && (sel_q != LOOP_SPD) &&
                ((es100 < $signed({10'd0, sp_q})) || (ei100 > $signed({10'd0, il_q})));
    if (!mode_q)        new_sel = LOOP_NONE;
    else if (enter_cur) new_sel = LOOP_CUR;
    else if (enter_spd) new_sel = LOOP_SPD;
    else                new_sel = sel_q;
    ki_new = enter_cur ? cki_q : ski_q;
  end

  always_comb begin
    kp_a    = (sel_q == LOOP_CUR) ? ckp_q : skp_q;
    ki_a    = (sel_q == LOOP_CUR) ? cki_q : ski_q;
    e_mag   = MAG_W'(e_q[33] ? -e_q : e_q);
    int_abs = int_q[INT_W-1] ? -int_q : int_q;
    int_mag = MAG_W'(int_abs);
    spd_abs = spd34[33] ? -spd34 : spd34;
    spd_mag = MAG_W'(spd_abs);
    // Gain products are truncated toward zero: shift the magnitude, then sign.
    p16     = $signed({2'b00, mul_p[56:16]});
    p_s     = e_q[33] ? -p16 : p16;
    num     = $signed({26'd0, last_q}) - p_s;
    num_mag = 41'(num[42] ? -num : num);
    inc_s   = $signed({27'd0, mul_p[64:32]});
    if (e_q[33]) inc_s = -inc_s;
    int_sum = int_q + inc_s;
    if (int_sum > ISUM_MAX)      int_sat = ISUM_MAX;
    else if (int_sum < ISUM_MIN) int_sat = ISUM_MIN;
    else                         int_sat = int_sum;
    y_sum = acc_q + (int_q[INT_W-1] ? -p16 : p16);
    if (y_sum > $signed({26'd0, ONE_Q16})) y_clamp = ONE_Q16;
    else if (y_sum < 0)                    y_clamp = '0;
    else                                   y_clamp = y_sum[16:0];
    fl_s = spd_q[31] ? -p16 : p16;
    if (fl_s > $signed({26'd0, y_q})) begin
      drive = (fl_s > $signed({26'd0, ONE_Q16})) ? ONE_Q16 : fl_s[16:0];
    end else begin
      drive = y_q;
    end
  end

  // Sequencer: next state and shared-unit control.
  always_comb begin
    state_d   = state_q;
    mul_en    = 1'b0;
    mul_a     = e_mag;
    mul_b     = MB_W'(kp_a);
    div_start = 1'b0;
    div_dvd   = {num_mag, 16'd0};
    div_dsr   = ki_a;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_SEL;
      ST_SEL: begin
        if (new_sel == LOOP_NONE)                      state_d = ST_FLR;
        else if (new_sel != sel_q && ki_new != '0)     state_d = ST_PMUL;
        else                                           state_d = ST_INC;
      end
      ST_PMUL: begin
        mul_en  = 1'b1;
        state_d = ST_PRE;
      end
      ST_PRE: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: if (div_ctl.done) state_d = ST_INC;
      ST_INC: begin
        mul_en  = 1'b1;
        mul_b   = h_q;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        mul_en  = 1'b1;
        state_d = ST_KI;
      end
      ST_KI: begin
        mul_en  = 1'b1;
        mul_a   = int_mag;
        mul_b   = MB_W'(ki_a);
        state_d = ST_SUM;
      end
      ST_SUM: state_d = ST_FLR;
      ST_FLR: begin
        mul_en  = 1'b1;
        mul_a   = spd_mag;
        mul_b   = MB_W'(emf_q);
        state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, setup registers and regulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= 1'b0;
      sp_q    <= RST_SPEED;
      il_q    <= RST_ILIM;
      ckp_q   <= RST_KP;
      cki_q   <= RST_KI;
      skp_q   <= RST_KP;
      ski_q   <= RST_KI;
      emf_q   <= RST_EMF;
      sel_q   <= LOOP_NONE;
      cint_q  <= '0;
      sint_q  <= '0;
      last_q  <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MODE:  mode_q <= cfg_wdata_i[0];
          CFG_SPEED: sp_q   <= cfg_wdata_i;
          CFG_ILIM:  il_q   <= cfg_wdata_i;
          CFG_CKP:   ckp_q  <= cfg_wdata_i[23:0];
          CFG_CKI:   cki_q  <= cfg_wdata_i[23:0];
          CFG_SKP:   skp_q  <= cfg_wdata_i[23:0];
          CFG_SKI:   ski_q  <= cfg_wdata_i[23:0];
          CFG_EMF:   emf_q  <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if (state_q == ST_SEL) begin
        sel_q <= new_sel;
        if (new_sel == LOOP_NONE) last_q <= ONE_Q16;
      end
      if (state_q == ST_SUM) begin
        last_q <= y_clamp;
        if (sel_q == LOOP_CUR) cint_q <= int_q[31:0];
        else                   sint_q <= int_q[31:0];
      end
      if (state_q == ST_FIN)                     mval_q <= 1'b1;
      else if (state_q == ST_OUT && m_axis_tready) mval_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cur_q <= s_axis_tdata[31:0];
        spd_q <= s_axis_tdata[63:32];
        h_q   <= s_axis_tdata[95:64];
      end
      ST_SEL: begin
        e_q <= (new_sel == LOOP_CUR) ? ei : es;
        if (new_sel == LOOP_NONE) begin
          y_q <= ONE_Q16;
        end else if (new_sel != sel_q) begin
          int_q <= '0;
        end else if (new_sel == LOOP_CUR) begin
          int_q <= INT_W'(cint_q);
        end else begin
          int_q <= INT_W'(sint_q);
        end
      end
      ST_PRE: nneg_q <= num[42];
      ST_DIV: begin
        if (div_ctl.done) begin
          int_q <= nneg_q ? -$signed({3'b000, div_q}) : $signed({3'b000, div_q});
        end
      end
      ST_ADD: int_q <= int_sat;
      ST_KI:  acc_q <= p_s;
      ST_SUM: y_q   <= y_clamp;
      ST_FIN: begin
        oy_q <= y_q;
        od_q <= drive;
        ol_q <= sel_q;
      end
      default: ;
    endcase
  end

  spcl_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  spcl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .ctl_o      (div_ctl),
    .quot_o     (div_q)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {6'd0, od_q, oy_q};
  assign m_axis_tuser  = ol_q;

  // Assertions.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in flight");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= ONE_Q16) && (m_axis_tdata[33:17] <= ONE_Q16))
    else $error("result beyond full scale");

  a_floor_raises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:17] >= m_axis_tdata[16:0])
    else $error("back-EMF floor lowered the output");

  a_none_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == LOOP_NONE) |-> m_axis_tdata[16:0] == ONE_Q16)
    else $error("no active loop but output below full scale");

  a_int_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cint_q <= 32'sd655360000) && (cint_q >= -32'sd655360000) &&
    (sint_q <= 32'sd655360000) && (sint_q >= -32'sd655360000))
    else $error("stored integral out of bounds");

endmodule
